@@ hw/rtl/msi_enc_pkg.sv @@
// msi_enc_pkg: types, constants and helper functions of the msi barcode encoder
// shared by the front, queue, back and top level files; no dependencies

package msi_enc_pkg;

    localparam int DIGIT_W  = 4;
    localparam int RUN_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_CHECK  = 1'd1;

    localparam logic [1:0] WMODE_1_2 = 2'd0;
    localparam logic [1:0] WMODE_1_3 = 2'd1;
    localparam logic [1:0] WMODE_2_5 = 2'd2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } in_item_t;

    typedef struct packed {
        logic             bar;
        logic [RUN_W-1:0] run_width;
        logic             end_of_run;
        logic             invalid_code;
    } out_item_t;

    // work handed from front to back
    typedef struct packed {
        logic               invalid;
        logic               start;
        logic               last;
        logic               check_en;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] check;
        logic [RUN_W-1:0]   narrow;
        logic [RUN_W-1:0]   wide;
    } job_t;

    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] k;
        k = {d, 1'b0};
        if (k > 5'd9)
        begin
            k = k - 5'd9;
        end
        return k[DIGIT_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10)
        begin
            s = s - 5'd10;
        end
        return s[DIGIT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/msi_enc_front.sv @@
// msi_enc_front: configuration registers, digit classification and luhn sums
// depends on msi_enc_pkg

module msi_enc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [msi_enc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msi_enc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  msi_enc_pkg::in_item_t              in_item,
    input  logic                               q_full,
    output logic                               q_push,
    output msi_enc_pkg::job_t                  q_job
);

    logic [1:0] width_mode_reg;
    logic       add_check_reg;
    logic       started_reg, started_next;
    logic       parity_reg, parity_next;
    logic [msi_enc_pkg::DIGIT_W-1:0] sum_even_reg, sum_even_next;
    logic [msi_enc_pkg::DIGIT_W-1:0] sum_odd_reg, sum_odd_next;
    logic [msi_enc_pkg::DIGIT_W-1:0] dbl;
    logic [msi_enc_pkg::DIGIT_W-1:0] sel_sum;
    logic       bad;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign bad      = in_item.digit > msi_enc_pkg::DIGIT_MAX;
    assign dbl      = msi_enc_pkg::luhn_double(in_item.digit);

    always_comb
    begin
        if (parity_reg)
        begin
            sum_even_next = msi_enc_pkg::add_mod10(sum_even_reg, in_item.digit);
            sum_odd_next  = msi_enc_pkg::add_mod10(sum_odd_reg, dbl);
            sel_sum       = sum_odd_next;
        end
        else
        begin
            sum_even_next = msi_enc_pkg::add_mod10(sum_even_reg, dbl);
            sum_odd_next  = msi_enc_pkg::add_mod10(sum_odd_reg, in_item.digit);
            sel_sum       = sum_even_next;
        end
        started_next = 1'b1;
        parity_next  = !parity_reg;
        if (bad || in_item.last_digit)
        begin
            started_next  = 1'b0;
            parity_next   = 1'b0;
            sum_even_next = '0;
            sum_odd_next  = '0;
        end
    end

    always_comb
    begin
        q_job.invalid  = bad;
        q_job.start    = !started_reg;
        q_job.last     = in_item.last_digit;
        q_job.check_en = in_item.last_digit && add_check_reg;
        q_job.digit    = in_item.digit;
        q_job.check    = (sel_sum == '0) ? '0 : 4'd10 - sel_sum;
        case (width_mode_reg)
            msi_enc_pkg::WMODE_2_5:
            begin
                q_job.narrow = 3'd2;
                q_job.wide   = 3'd5;
            end
            msi_enc_pkg::WMODE_1_3:
            begin
                q_job.narrow = 3'd1;
                q_job.wide   = 3'd3;
            end
            default:
            begin
                q_job.narrow = 3'd1;
                q_job.wide   = 3'd2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mode_reg <= '0;
            add_check_reg  <= 1'b0;
            started_reg    <= 1'b0;
            parity_reg     <= 1'b0;
            sum_even_reg   <= '0;
            sum_odd_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == msi_enc_pkg::CFG_WIDTH_MODE)
            begin
                width_mode_reg <= cfg_data[1:0];
            end
            if (cfg_we && cfg_index == msi_enc_pkg::CFG_ADD_CHECK)
            begin
                add_check_reg <= cfg_data[0];
            end
            if (q_push)
            begin
                started_reg  <= started_next;
                parity_reg   <= parity_next;
                sum_even_reg <= sum_even_next;
                sum_odd_reg  <= sum_odd_next;
            end
        end
    end

endmodule

@@ hw/rtl/msi_enc_fifo.sv @@
// msi_enc_fifo: short job queue between front and back
// depends on msi_enc_pkg

module msi_enc_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msi_enc_pkg::job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              avail,
    output msi_enc_pkg::job_t head_job
);

    msi_enc_pkg::job_t mem_reg [msi_enc_pkg::QDEPTH];
    logic [msi_enc_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [msi_enc_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == msi_enc_pkg::QCNT_W'(msi_enc_pkg::QDEPTH);
    assign avail    = count_reg != '0;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/msi_enc_back.sv @@
// msi_enc_back: run sequencer that turns queued jobs into bar/space runs
// depends on msi_enc_pkg

module msi_enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_avail,
    input  msi_enc_pkg::job_t      q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output msi_enc_pkg::out_item_t out_item
);

    typedef enum logic [2:0] {PH_START, PH_DATA, PH_CHECK, PH_STOP, PH_ERR} phase_t;

    phase_t phase_reg, phase_next, phase_init;
    logic   busy_reg;
    logic [2:0] idx_reg;
    msi_enc_pkg::job_t job_reg;
    logic   out_valid_reg;
    msi_enc_pkg::out_item_t out_reg, run;

    logic take, advance, final_step, job_done, bit_val;
    logic [msi_enc_pkg::DIGIT_W-1:0] cur_digit;

    assign take      = !out_valid_reg || !out_stall;
    assign advance   = busy_reg && take;
    assign cur_digit = (phase_reg == PH_CHECK) ? job_reg.check : job_reg.digit;
    assign bit_val   = cur_digit[~idx_reg[2:1]];
    assign q_pop     = q_avail && (!busy_reg || (advance && job_done));
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        phase_init = q_head.invalid ? PH_ERR : (q_head.start ? PH_START : PH_DATA);
    end

    always_comb
    begin
        run.bar          = !idx_reg[0];
        run.run_width    = job_reg.narrow;
        run.invalid_code = 1'b0;
        final_step       = 1'b0;
        job_done         = 1'b0;
        phase_next       = phase_reg;
        case (phase_reg)
            PH_START:
            begin
                run.run_width = idx_reg[0] ? job_reg.narrow : job_reg.wide;
                final_step    = idx_reg[0];
                phase_next    = PH_DATA;
            end
            PH_DATA:
            begin
                run.run_width = (bit_val ^ idx_reg[0]) ? job_reg.wide : job_reg.narrow;
                final_step    = idx_reg == 3'd7;
                job_done      = final_step && !job_reg.last;
                phase_next    = job_reg.check_en ? PH_CHECK : PH_STOP;
            end
            PH_CHECK:
            begin
                run.run_width = (bit_val ^ idx_reg[0]) ? job_reg.wide : job_reg.narrow;
                final_step    = idx_reg == 3'd7;
                phase_next    = PH_STOP;
            end
            PH_STOP:
            begin
                run.run_width = idx_reg[0] ? job_reg.wide : job_reg.narrow;
                final_step    = idx_reg == 3'd2;
                job_done      = final_step;
            end
            PH_ERR:
            begin
                run.bar          = 1'b0;
                run.run_width    = '0;
                run.invalid_code = 1'b1;
                final_step       = 1'b1;
                job_done         = 1'b1;
            end
            default:
            begin
                run.bar       = 1'b0;
                run.run_width = '0;
                final_step    = 1'b1;
                job_done      = 1'b1;
            end
        endcase
        run.end_of_run = job_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_reg   <= q_head;
                busy_reg  <= 1'b1;
                phase_reg <= phase_init;
                idx_reg   <= '0;
            end
            else if (advance && job_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                if (final_step)
                begin
                    phase_reg <= phase_next;
                    idx_reg   <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= run;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_start_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && phase_reg == PH_START |-> idx_reg < 3'd2)
        else $error("start pattern index out of range");
    a_stop_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && phase_reg == PH_STOP |-> idx_reg < 3'd3)
        else $error("stop pattern index out of range");
    a_err_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.invalid_code |-> out_reg.end_of_run && out_reg.run_width == '0)
        else $error("error item not a single closing run");
    a_good_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.invalid_code |-> out_reg.run_width != '0)
        else $error("valid run of zero width");
`endif

endmodule

@@ hw/rtl/msi_barcode_module_encoder_top.sv @@
// msi_barcode_module_encoder_top: top level of the msi barcode run encoder
// depends on msi_enc_pkg, msi_enc_front, msi_enc_fifo, msi_enc_back
//
// Digits enter one per item and leave as bar/space runs, one run per clock on the output
// port while out_stall is low: 8 runs for a digit, 2 more on the first digit of a message
// (start pattern), 3 more on the last (stop pattern) and 8 more when the check digit is
// enabled, 1 run for a non-decimal digit. The output rate is set by the run sequencer in
// the back end; the front end takes a digit in any cycle while its four-entry job queue
// has room, so input and output stall independently; config writes apply to later digits.

module msi_barcode_module_encoder_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [msi_enc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msi_enc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  msi_enc_pkg::in_item_t              in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output msi_enc_pkg::out_item_t             out_item
);

    logic q_push, q_full, q_pop, q_avail;
    msi_enc_pkg::job_t push_job, head_job;

    msi_enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    msi_enc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head_job (head_job)
    );

    msi_enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_head    (head_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

@@ tb/sv/msi_barcode_module_encoder_top_tb.sv @@
// msi_barcode_module_encoder_top_tb: self-checking bench for the msi barcode run encoder;
// predicts each run (start, data, luhn check digit, stop, abort) and compares field by field
// depends on msi_enc_pkg and msi_barcode_module_encoder_top

module msi_barcode_module_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msi_enc_pkg::*;

    localparam logic [1:0] WMODE_ALIAS = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;

    msi_barcode_module_encoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    in_item_t  digit_q[$];
    out_item_t run_q[$];
    int        bad_runs = 0;
    bit        quiet = 1'b0;

    logic [1:0] wmode_cfg = WMODE_1_2;
    logic       check_cfg = 1'b0;
    logic       msg_open = 1'b0;
    logic       pos_odd = 1'b0;
    logic [3:0] sum_even_dbl = '0;
    logic [3:0] sum_odd_dbl = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic out_item_t make_run(input logic bar, input int w);
        out_item_t r;
        r.bar = bar;
        r.run_width = w[RUN_W-1:0];
        r.end_of_run = 1'b0;
        r.invalid_code = 1'b0;
        return r;
    endfunction

    function automatic int doubled(input int d);
        int k;
        k = d * 2;
        return (k > 9) ? k - 9 : k;
    endfunction

    task automatic add_symbol(input int d, input int narrow, input int wide);
        for (int b = 3; b >= 0; b--)
        begin
            if (d[b])
            begin
                run_q.push_back(make_run(1'b1, wide));
                run_q.push_back(make_run(1'b0, narrow));
            end
            else
            begin
                run_q.push_back(make_run(1'b1, narrow));
                run_q.push_back(make_run(1'b0, wide));
            end
        end
    endtask

    task automatic clear_message();
        msg_open = 1'b0;
        pos_odd = 1'b0;
        sum_even_dbl = '0;
        sum_odd_dbl = '0;
    endtask

    task automatic predict_runs(input in_item_t it);
        out_item_t r;
        int        d;
        int        narrow;
        int        wide;
        int        s;
        d = it.digit;
        if (d > 9)
        begin
            r = make_run(1'b0, 0);
            r.end_of_run = 1'b1;
            r.invalid_code = 1'b1;
            run_q.push_back(r);
            clear_message();
            return;
        end
        case (wmode_cfg)
            WMODE_2_5:
            begin
                narrow = 2;
                wide = 5;
            end
            WMODE_1_3:
            begin
                narrow = 1;
                wide = 3;
            end
            default:
            begin
                narrow = 1;
                wide = 2;
            end
        endcase
        if (!msg_open)
        begin
            run_q.push_back(make_run(1'b1, wide));
            run_q.push_back(make_run(1'b0, narrow));
            msg_open = 1'b1;
        end
        add_symbol(d, narrow, wide);
        if (!pos_odd)
        begin
            sum_even_dbl = 4'((int'(sum_even_dbl) + doubled(d)) % 10);
            sum_odd_dbl = 4'((int'(sum_odd_dbl) + d) % 10);
        end
        else
        begin
            sum_even_dbl = 4'((int'(sum_even_dbl) + d) % 10);
            sum_odd_dbl = 4'((int'(sum_odd_dbl) + doubled(d)) % 10);
        end
        if (it.last_digit)
        begin
            if (check_cfg)
            begin
                s = !pos_odd ? int'(sum_even_dbl) : int'(sum_odd_dbl);
                add_symbol((s != 0) ? 10 - s : 0, narrow, wide);
            end
            run_q.push_back(make_run(1'b1, narrow));
            run_q.push_back(make_run(1'b0, wide));
            run_q.push_back(make_run(1'b1, narrow));
            clear_message();
        end
        else
        begin
            pos_odd = ~pos_odd;
        end
        r = run_q.pop_back();
        r.end_of_run = 1'b1;
        run_q.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                predict_runs(in_item);
            end
            if (digit_q.size() != 0 && (quiet || $urandom_range(99) >= 7))
            begin
                in_valid <= 1'b1;
                in_item <= digit_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (run_q.size() == 0)
                begin
                    bad_runs++;
                    if (bad_runs <= 10)
                    begin
                        $display("unexpected run: bar %0d width %0d end %0d invalid %0d",
                                 out_item.bar, out_item.run_width, out_item.end_of_run,
                                 out_item.invalid_code);
                    end
                end
                else
                begin
                    want = run_q.pop_front();
                    if (out_item.bar !== want.bar || out_item.run_width !== want.run_width ||
                        out_item.end_of_run !== want.end_of_run ||
                        out_item.invalid_code !== want.invalid_code)
                    begin
                        bad_runs++;
                        if (bad_runs <= 10)
                        begin
                            $display({"run mismatch: expected bar %0d width %0d end %0d ",
                                      "invalid %0d, got bar %0d width %0d end %0d invalid %0d"},
                                     want.bar, want.run_width, want.end_of_run,
                                     want.invalid_code, out_item.bar, out_item.run_width,
                                     out_item.end_of_run, out_item.invalid_code);
                        end
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_WIDTH_MODE)
        begin
            wmode_cfg = val;
        end
        else
        begin
            check_cfg = val[0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send(input int d, input bit fin);
        in_item_t it;
        it.digit = d[DIGIT_W-1:0];
        it.last_digit = fin;
        digit_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (digit_q.size() != 0 || in_valid || run_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic send_messages(input int count);
        int len;
        int d;
        bit fin;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            for (int k = 0; k < len && sent < count; k++)
            begin
                d = ($urandom_range(99) < 5) ? $urandom_range(10, 15) : $urandom_range(9);
                fin = (k == len - 1) || (sent == count - 1);
                if ($urandom_range(99) < 3)
                begin
                    fin = $urandom_range(1);
                end
                send(d, fin);
                sent++;
            end
        end
    endtask

    task automatic random_phase(input logic [1:0] wm, input logic chk, input int count);
        wait_idle();
        write_reg(CFG_WIDTH_MODE, wm);
        write_reg(CFG_ADD_CHECK, {1'b0, chk});
        send_messages(count);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_WIDTH_MODE, WMODE_1_2);
        write_reg(CFG_ADD_CHECK, 2'd1);
        for (int d = 0; d <= 9; d++)
        begin
            send(d, d == 9);
        end
        send(9, 1'b1);
        send(0, 1'b1);
        send(5, 1'b0);
        send(15, 1'b0);
        send(10, 1'b0);
        send(12, 1'b1);
        send(7, 1'b0);
        send(3, 1'b1);

        wait_idle();
        write_reg(CFG_WIDTH_MODE, WMODE_ALIAS);
        write_reg(CFG_ADD_CHECK, 2'd0);
        send(4, 1'b0);
        send(2, 1'b1);
        send(1, 1'b1);
        wait_idle();
        write_reg(CFG_WIDTH_MODE, WMODE_2_5);
        send(8, 1'b0);
        send(6, 1'b1);

        random_phase(WMODE_1_3, 1'b1, 43);
        random_phase(WMODE_2_5, 1'b0, 43);
        wait_idle();
        quiet = 1'b1;
        random_phase(WMODE_2_5, 1'b1, 43);
        wait_idle();
        quiet = 1'b0;
        random_phase(WMODE_1_2, 1'b0, 43);
        random_phase(WMODE_ALIAS, 1'b1, 43);
        random_phase(WMODE_1_3, 1'b0, 43);

        wait_idle();
        repeat (30) @(posedge clk);
        if (bad_runs == 0 && run_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/msi_enc_pkg.sv
hw/rtl/msi_enc_front.sv
hw/rtl/msi_enc_fifo.sv
hw/rtl/msi_enc_back.sv
hw/rtl/msi_barcode_module_encoder_top.sv
tb/sv/msi_barcode_module_encoder_top_tb.sv
